FILE: rtl/core/b2ss_pkg.sv
`timescale 1ns / 1ps

package b2ss_pkg;

   localparam int ValueWidth   = 16;
   localparam int DigitWidth   = 4;
   localparam int DigitCount   = 5;
   localparam int BcdWidth     = DigitWidth * DigitCount;
   localparam int AccWidth     = BcdWidth + ValueWidth;
   localparam int BitsPerStage = 4;
   localparam int StageCount   = ValueWidth / BitsPerStage;
   localparam int SegWidth     = 8;

   localparam logic [SegWidth-1:0] SegBlank = 8'hFF;

   typedef struct packed {
      logic                  valid;
      logic [BcdWidth-1:0]   bcd;
      logic [ValueWidth-1:0] bin;
   } stage_type;

   typedef struct packed {
      logic                valid;
      logic [SegWidth-1:0] ones;
      logic [SegWidth-1:0] tens;
      logic [SegWidth-1:0] hundreds;
      logic [SegWidth-1:0] thousands;
   } result_type;

   // One double-dabble step: correct every digit of five or more, then shift left.
   function automatic logic [AccWidth-1:0] dabble_shift(input logic [AccWidth-1:0] acc);
      logic [AccWidth-1:0] adj;
      adj = acc;
      for (int d = 0; d < DigitCount; d++) begin
         if (adj[ValueWidth + DigitWidth*d +: DigitWidth] >= 4'd5) begin
            adj[ValueWidth + DigitWidth*d +: DigitWidth] =
               adj[ValueWidth + DigitWidth*d +: DigitWidth] + 4'd3;
         end
      end
      return {adj[AccWidth-2:0], 1'b0};
   endfunction

   // Active-low segment pattern, bit 7 is the decimal point and bit 0 segment A.
   function automatic logic [SegWidth-1:0] seg_code(input logic [DigitWidth-1:0] digit);
      logic [SegWidth-1:0] code;
      case (digit)
         4'd0: code = 8'b1100_0000;
         4'd1: code = 8'b1111_1001;
         4'd2: code = 8'b1010_0100;
         4'd3: code = 8'b1011_0000;
         4'd4: code = 8'b1001_1001;
         4'd5: code = 8'b1001_0010;
         4'd6: code = 8'b1000_0010;
         4'd7: code = 8'b1111_1000;
         4'd8: code = 8'b1000_0000;
         4'd9: code = 8'b1001_0000;
         default: code = SegBlank;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/core/b2ss_dabble_stage.sv
`timescale 1ns / 1ps

module b2ss_dabble_stage (
   input  logic                clock,
   input  logic                reset,
   input  b2ss_pkg::stage_type in_stage,
   output b2ss_pkg::stage_type out_stage
);

   b2ss_pkg::stage_type      stage_in;
   b2ss_pkg::stage_type      stage_ff;
   logic [b2ss_pkg::AccWidth-1:0] acc;

   always_comb begin
      acc = {in_stage.bcd, in_stage.bin};
      for (int i = 0; i < b2ss_pkg::BitsPerStage; i++) begin
         acc = b2ss_pkg::dabble_shift(acc);
      end
      stage_in.valid = in_stage.valid;
      stage_in.bcd   = acc[b2ss_pkg::AccWidth-1:b2ss_pkg::ValueWidth];
      stage_in.bin   = acc[b2ss_pkg::ValueWidth-1:0];
   end

   always_ff @(posedge clock) begin
      stage_ff.bcd <= stage_in.bcd;
      stage_ff.bin <= stage_in.bin;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   assign out_stage = stage_ff;

endmodule

FILE: rtl/core/b2ss_seg_stage.sv
`timescale 1ns / 1ps

module b2ss_seg_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  b2ss_pkg::stage_type  in_stage,
   output b2ss_pkg::result_type out_result
);

   b2ss_pkg::result_type result_in;
   b2ss_pkg::result_type result_ff;
   logic [b2ss_pkg::DigitWidth-1:0] d0, d1, d2, d3, d4;
   logic blank3, blank2, blank1;

   always_comb begin
      d0 = in_stage.bcd[3:0];
      d1 = in_stage.bcd[7:4];
      d2 = in_stage.bcd[11:8];
      d3 = in_stage.bcd[15:12];
      d4 = in_stage.bcd[19:16];
      blank3 = (d4 == 4'd0) && (d3 == 4'd0);
      blank2 = blank3 && (d2 == 4'd0);
      blank1 = blank2 && (d1 == 4'd0);
      result_in.valid     = in_stage.valid;
      result_in.ones      = b2ss_pkg::seg_code(d0);
      result_in.tens      = blank1 ? b2ss_pkg::SegBlank : b2ss_pkg::seg_code(d1);
      result_in.hundreds  = blank2 ? b2ss_pkg::SegBlank : b2ss_pkg::seg_code(d2);
      result_in.thousands = blank3 ? b2ss_pkg::SegBlank : b2ss_pkg::seg_code(d3);
   end

   always_ff @(posedge clock) begin
      result_ff.ones      <= result_in.ones;
      result_ff.tens      <= result_in.tens;
      result_ff.hundreds  <= result_in.hundreds;
      result_ff.thousands <= result_in.thousands;
      if (reset) begin
         result_ff.valid <= 1'b0;
      end else begin
         result_ff.valid <= result_in.valid;
      end
   end

   assign out_result = result_ff;

   a_valid_follows : assert property (@(posedge clock) disable iff (reset)
      in_stage.valid |=> result_ff.valid)
      else $error("request lost in segment stage");

   a_ones_shown : assert property (@(posedge clock) disable iff (reset)
      result_ff.valid |-> result_ff.ones != b2ss_pkg::SegBlank)
      else $error("ones digit blanked");

   a_blank_order_hi : assert property (@(posedge clock) disable iff (reset)
      result_ff.valid && result_ff.thousands != b2ss_pkg::SegBlank
      |-> result_ff.hundreds != b2ss_pkg::SegBlank)
      else $error("hundreds blanked below a shown thousands digit");

   a_blank_order_lo : assert property (@(posedge clock) disable iff (reset)
      result_ff.valid && result_ff.hundreds != b2ss_pkg::SegBlank
      |-> result_ff.tens != b2ss_pkg::SegBlank)
      else $error("tens blanked below a shown hundreds digit");

endmodule

FILE: rtl/core/binary_to_seven_segment_display.sv
`timescale 1ns / 1ps

// Four-digit binary to seven-segment decoder.
// A request is taken at a rising edge where start is high and busy is low.
// busy is always low, so a new request may be issued in every cycle.
// req_value carries the 16-bit unsigned value to be shown.
// Each request yields one result: rsp_valid is high for exactly one cycle
// with the four active-low segment bytes on the rsp_ ports, bit 7 being
// the decimal point. Leading zeros are blanked to all segments off, and
// the thousands digit wraps modulo ten above 9999.
// The value is converted by four double-dabble stages of four bits each,
// followed by one segment encoding stage, each stage ending in a register
// that carries the valid bit along with the data; throughput is one per cycle.
// A synchronous reset clears every valid bit in the pipeline, dropping
// requests in flight. The receiver cannot stall, so there is no back-pressure.
module binary_to_seven_segment_display (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_ones_segments,
   output logic [7:0]  rsp_tens_segments,
   output logic [7:0]  rsp_hundreds_segments,
   output logic [7:0]  rsp_thousands_segments
);

   b2ss_pkg::stage_type  stage_chain [b2ss_pkg::StageCount+1];
   b2ss_pkg::result_type result;

   assign busy = 1'b0;

   always_comb begin
      stage_chain[0].valid = start && !busy;
      stage_chain[0].bcd   = '0;
      stage_chain[0].bin   = req_value;
   end

   for (genvar s = 0; s < b2ss_pkg::StageCount; s++) begin : g_dabble
      b2ss_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (stage_chain[s]),
         .out_stage (stage_chain[s+1])
      );
   end

   b2ss_seg_stage u_seg (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (stage_chain[b2ss_pkg::StageCount]),
      .out_result (result)
   );

   assign rsp_valid              = result.valid;
   assign rsp_ones_segments      = result.ones;
   assign rsp_tens_segments      = result.tens;
   assign rsp_hundreds_segments  = result.hundreds;
   assign rsp_thousands_segments = result.thousands;

endmodule
